@@ src/aps_pkg.sv @@
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the aging priority task scheduler
// Holds the request and result structs, the command and status codes, the
// configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package aps_pkg;

  // Table and field sizes.
  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 32;
  localparam int PRI_W     = 7;
  localparam int REQ_PRI_W = 8;
  localparam int PER_W     = 8;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // The quotient of the aging divide is known to stay below the cap.
  localparam int QUO_W  = PRI_W;
  localparam int DIVD_W = PRI_W + PER_W;

  // Register reset values.
  localparam logic [PER_W-1:0] AGING_PERIOD_RST = PER_W'(20);
  localparam logic [PRI_W-1:0] PRIORITY_CAP_RST = PRI_W'(100);
  localparam logic [PRI_W-1:0] RUN_PENALTY_RST  = PRI_W'(2);

  // Command codes.
  localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_PRI = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_START   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_SLOT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_PENALTY  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    slot_id;
    logic [REQ_PRI_W-1:0] requested_priority;
    logic [TIME_W-1:0]    now_ms;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] chosen_slot;
    logic              found;
    logic [STAT_W-1:0] status;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PREP,
    S_AGE_LOAD,
    S_AGE_DIV,
    S_PICK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ src/aging_priority_task_scheduler_core.sv @@
// Create, set priority, finish and unknown commands go from decode straight to
// the result; start compares one slot per cycle. Tick frees finished slots and
// ages the rest, saturating long waits at once and dividing the others on the
// bit-serial aging divider, which serves the slots one after another, then picks.
// One request is in work at a time; the result register lets the next request be
// taken while a result waits. Synchronous reset empties the table.
// ----------------------------------------------------------------------------
// aging_priority_task_scheduler_core: task slot table with aging scheduler
// A small sequencer walks the slot table for aging and for choosing the task
// to run, sharing one divider for the aging step.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_priority_task_scheduler_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire aps_pkg::in_req_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output aps_pkg::out_rsp_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [aps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [aps_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int N  = aps_pkg::MAX_TASKS;
  localparam int SW = aps_pkg::SLOT_W;
  localparam int PW = aps_pkg::PRI_W;
  localparam int TW = aps_pkg::TIME_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(N - 1);

  aps_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [aps_pkg::PER_W-1:0] aging_r;
  logic [PW-1:0]             cap_r;
  logic [PW-1:0]             pen_r;
  logic [aps_pkg::PER_W-1:0] period;

  // Slot table.
  logic [N-1:0]  valid_r, valid_nxt;
  logic [N-1:0]  fin_r, fin_nxt;
  logic [PW-1:0] pri_r [N];
  logic [PW-1:0] pri_nxt [N];
  logic [TW-1:0] last_r [N];
  logic [TW-1:0] last_nxt [N];
  logic [SW-1:0] cur_r, cur_nxt;

  // Request, walk and result registers.
  aps_pkg::in_req_t  req_r, req_nxt;
  aps_pkg::out_rsp_t res_r, res_nxt;
  aps_pkg::out_rsp_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic [SW-1:0]     best_r, best_nxt;
  logic [PW-1:0]     best_pri_r, best_pri_nxt;
  logic              best_found_r, best_found_nxt;
  logic              skip_fin_r, skip_fin_nxt;
  logic [aps_pkg::DIVD_W-1:0] thr_r, thr_nxt;

  // Divider hookup.
  logic                       div_start;
  logic [aps_pkg::DIVD_W-1:0] div_dividend;
  logic                       div_done;
  logic [aps_pkg::QUO_W-1:0]  div_quo;

  // Scratch values of the sequencer.
  logic [TW-1:0] diff;
  logic [PW:0]   aged_sum;
  logic          free_hit;
  logic [SW-1:0] free_idx;
  logic          cand;
  logic          pick_kind;

  assign period    = (aging_r == '0) ? aps_pkg::PER_W'(1) : aging_r;
  assign diff      = req_r.now_ms - last_r[idx_r];
  assign aged_sum  = {1'b0, pri_r[idx_r]} + {1'b0, div_quo};
  assign cand      = valid_r[idx_r] && !(skip_fin_r && fin_r[idx_r]);
  assign pick_kind = (req_r.kind == aps_pkg::KIND_START) || (req_r.kind == aps_pkg::KIND_TICK);

  // Lowest free slot for create.
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  aps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer: next state and table updates.
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    fin_nxt        = fin_r;
    pri_nxt        = pri_r;
    last_nxt       = last_r;
    cur_nxt        = cur_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    best_pri_nxt   = best_pri_r;
    best_found_nxt = best_found_r;
    skip_fin_nxt   = skip_fin_r;
    thr_nxt        = thr_r;
    div_start      = 1'b0;
    div_dividend   = diff[aps_pkg::DIVD_W-1:0];

    // The taken result leaves the output register.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      aps_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = aps_pkg::S_DECODE;
        end
      end

      aps_pkg::S_DECODE: begin
        res_nxt        = '0;
        idx_nxt        = '0;
        best_nxt       = '0;
        best_pri_nxt   = '0;
        best_found_nxt = 1'b0;
        skip_fin_nxt   = 1'b0;
        state_nxt      = aps_pkg::S_DONE;
        unique case (req_r.kind) inside
          aps_pkg::KIND_CREATE: begin
            if (free_hit) begin
              valid_nxt[free_idx] = 1'b1;
              fin_nxt[free_idx]   = 1'b0;
              pri_nxt[free_idx]   = '0;
              last_nxt[free_idx]  = req_r.now_ms;
              res_nxt.chosen_slot = free_idx;
              res_nxt.found       = 1'b1;
            end else begin
              res_nxt.status = aps_pkg::STAT_FULL;
            end
          end
          aps_pkg::KIND_SET_PRI, aps_pkg::KIND_FINISH: begin
            if (!valid_r[req_r.slot_id]) begin
              res_nxt.status = aps_pkg::STAT_BAD_SLOT;
            end else if (req_r.kind == aps_pkg::KIND_SET_PRI) begin
              pri_nxt[req_r.slot_id] = ({1'b0, req_r.requested_priority} < {2'b00, cap_r})
                                       ? req_r.requested_priority[PW-1:0] : cap_r;
            end else begin
              fin_nxt[req_r.slot_id] = 1'b1;
            end
          end
          aps_pkg::KIND_START: begin
            state_nxt = aps_pkg::S_PICK;
          end
          aps_pkg::KIND_TICK: begin
            skip_fin_nxt = 1'b1;
            state_nxt    = aps_pkg::S_PREP;
          end
          default: begin
            state_nxt = aps_pkg::S_DONE;
          end
        endcase
      end

      // Free finished slots, charge the running task and set the saturation bound.
      aps_pkg::S_PREP: begin
        for (int i = 0; i < N; i++) begin
          if (fin_r[i] && (SW'(i) != cur_r)) begin
            valid_nxt[i] = 1'b0;
          end
        end
        if (valid_r[cur_r]) begin
          pri_nxt[cur_r] = (pri_r[cur_r] > pen_r) ? (pri_r[cur_r] - pen_r) : '0;
        end
        thr_nxt   = aps_pkg::DIVD_W'(cap_r) * aps_pkg::DIVD_W'(period);
        state_nxt = aps_pkg::S_AGE_LOAD;
      end

      // Age one slot: saturate at once when the wait is long, else divide.
      aps_pkg::S_AGE_LOAD: begin
        if (valid_r[idx_r] && (diff < TW'(thr_r))) begin
          div_start = 1'b1;
          state_nxt = aps_pkg::S_AGE_DIV;
        end else begin
          if (valid_r[idx_r]) begin
            pri_nxt[idx_r] = cap_r;
          end
          idx_nxt   = idx_r + SW'(1);
          state_nxt = (idx_r == LAST_SLOT) ? aps_pkg::S_PICK : aps_pkg::S_AGE_LOAD;
        end
      end

      aps_pkg::S_AGE_DIV: begin
        if (div_done) begin
          pri_nxt[idx_r] = (aged_sum > {1'b0, cap_r}) ? cap_r : aged_sum[PW-1:0];
          idx_nxt        = idx_r + SW'(1);
          state_nxt      = (idx_r == LAST_SLOT) ? aps_pkg::S_PICK : aps_pkg::S_AGE_LOAD;
        end
      end

      // Compare one slot per cycle; strict greater keeps the lowest index on ties.
      aps_pkg::S_PICK: begin
        if (cand && (!best_found_r || (pri_r[idx_r] > best_pri_r))) begin
          best_nxt       = idx_r;
          best_pri_nxt   = pri_r[idx_r];
          best_found_nxt = 1'b1;
        end
        idx_nxt = idx_r + SW'(1);
        if (idx_r == LAST_SLOT) begin
          state_nxt = aps_pkg::S_DONE;
        end
      end

      // Commit the choice and hand the result over once the output is free.
      aps_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          if (pick_kind) begin
            out_nxt = '0;
            if (best_found_r) begin
              cur_nxt             = best_r;
              out_nxt.chosen_slot = best_r;
              out_nxt.found       = 1'b1;
              if (req_r.kind == aps_pkg::KIND_TICK) begin
                last_nxt[best_r] = req_r.now_ms;
              end
            end
          end
          out_valid_nxt = 1'b1;
          state_nxt     = aps_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = aps_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aps_pkg::S_IDLE;
      valid_r      <= '0;
      fin_r        <= '0;
      cur_r        <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      best_found_r <= 1'b0;
      skip_fin_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      fin_r        <= fin_nxt;
      cur_r        <= cur_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      best_found_r <= best_found_nxt;
      skip_fin_r   <= skip_fin_nxt;
    end
  end

  // Payload state.
  always_ff @(posedge clk) begin
    pri_r      <= pri_nxt;
    last_r     <= last_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    best_r     <= best_nxt;
    best_pri_r <= best_pri_nxt;
    thr_r      <= thr_nxt;
  end

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_r <= aps_pkg::AGING_PERIOD_RST;
      cap_r   <= aps_pkg::PRIORITY_CAP_RST;
      pen_r   <= aps_pkg::RUN_PENALTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aps_pkg::CFG_AGING_PERIOD: aging_r <= cfg_data;
        aps_pkg::CFG_PRIORITY_CAP: cap_r   <= cfg_data[PW-1:0];
        aps_pkg::CFG_RUN_PENALTY:  pen_r   <= cfg_data[PW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != aps_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ src/aps_div.sv @@
// ----------------------------------------------------------------------------
// aps_div: bit-serial divider for the aging step
// Divides a short elapsed time by the aging period, one quotient bit per
// cycle. The caller guarantees that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [aps_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [aps_pkg::PER_W-1:0]   divisor,
  output logic                             done,
  output logic [aps_pkg::QUO_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(aps_pkg::QUO_W + 1);

  logic [aps_pkg::PER_W-1:0] rem_r, rem_nxt;
  logic [aps_pkg::QUO_W-1:0] dvd_r, dvd_nxt;
  logic [aps_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [aps_pkg::PER_W:0]   trial;
  logic                      take;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, dvd_r[aps_pkg::QUO_W-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      // The high part is already below the divisor since the quotient is short.
      rem_nxt = dividend[aps_pkg::DIVD_W-1:aps_pkg::QUO_W];
      dvd_nxt = dividend[aps_pkg::QUO_W-1:0];
      quo_nxt = '0;
      cnt_nxt = CNT_W'(aps_pkg::QUO_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = take ? aps_pkg::PER_W'(trial - {1'b0, divisor})
                     : trial[aps_pkg::PER_W-1:0];
      dvd_nxt = {dvd_r[aps_pkg::QUO_W-2:0], 1'b0};
      quo_nxt = {quo_r[aps_pkg::QUO_W-2:0], take};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the aging priority task scheduler core
// A table of directed requests opens the run, then random request streams
// follow under several register settings. Every accepted request is run
// through a local model of the slot table and its result is queued. Each
// result the core returns is checked field by field against that queue.
// ----------------------------------------------------------------------------

module tb_top;
  import aps_pkg::*;

  localparam int HALF_NS       = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int PHASES        = 6;
  localparam int PHASE_CMDS    = 150;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS   = 10;

  // Command codes that the core ignores.
  localparam logic [KIND_W-1:0] KIND_RESERVED_LO = KIND_TICK + 1'b1;
  localparam logic [KIND_W-1:0] KIND_RESERVED_HI = '1;

  typedef struct {
    in_req_t  cmd;
    bit       fixed;
    out_rsp_t rsp;
  } plan_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_req_t              in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_rsp_t             out_data;
  logic                 cfg_ready;

  // Local copy of the slot table and of the registers.
  bit                tbl_valid [MAX_TASKS];
  bit                tbl_done  [MAX_TASKS];
  logic [PRI_W-1:0]  tbl_pri   [MAX_TASKS];
  logic [TIME_W-1:0] tbl_stamp [MAX_TASKS];
  logic [SLOT_W-1:0] run_slot    = '0;
  logic [PER_W-1:0]  cfg_period  = AGING_PERIOD_RST;
  logic [PRI_W-1:0]  cfg_cap     = PRIORITY_CAP_RST;
  logic [PRI_W-1:0]  cfg_penalty = RUN_PENALTY_RST;

  out_rsp_t          pending_sched_results[$];
  int                err_count   = 0;
  int                burst_left  = 0;
  int                kinds_seen[8];
  int                n_full      = 0;
  int                n_bad_slot  = 0;
  int                n_no_task   = 0;
  int                n_settings  = 1;
  bit [31:0]         rx_cycle    = '0;
  out_rsp_t          want;
  logic [TIME_W-1:0] sim_ms      = '0;

  aging_priority_task_scheduler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_NS) clk = ~clk;

  // Hard stop in case the core hangs.
  initial begin
    #(1_000_000 * 2 * HALF_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_req_t make_cmd(input logic [KIND_W-1:0] kind, input int slot,
                                       input int pri, input logic [TIME_W-1:0] now);
    in_req_t c;
    c.kind               = kind;
    c.slot_id            = SLOT_W'(slot);
    c.requested_priority = REQ_PRI_W'(pri);
    c.now_ms             = now;
    return c;
  endfunction

  function automatic out_rsp_t make_rsp(input int slot, input bit found,
                                        input logic [STAT_W-1:0] status);
    out_rsp_t r;
    r.chosen_slot = SLOT_W'(slot);
    r.found       = found;
    r.status      = status;
    return r;
  endfunction

  // Highest-priority live slot, lowest index on ties; -1 when there is none.
  function automatic int best_slot(input bit skip_done);
    int b;
    b = -1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (!tbl_valid[i] || (skip_done && tbl_done[i])) continue;
      if (b < 0 || tbl_pri[i] > tbl_pri[b]) b = i;
    end
    return b;
  endfunction

  // Applies one scheduler command to the local table and returns its result.
  function automatic out_rsp_t sched_step(input in_req_t cmd);
    out_rsp_t          rsp;
    int                pick;
    longint unsigned   period;
    longint unsigned   age;
    longint unsigned   grown;
    logic [TIME_W-1:0] waited;
    rsp  = '0;
    pick = -1;
    case (cmd.kind)
      KIND_CREATE: begin
        for (int i = 0; i < MAX_TASKS; i++)
          if (!tbl_valid[i] && pick < 0) pick = i;
        if (pick < 0) begin
          rsp.status = STAT_FULL;
        end else begin
          tbl_valid[pick] = 1'b1;
          tbl_done[pick]  = 1'b0;
          tbl_pri[pick]   = '0;
          tbl_stamp[pick] = cmd.now_ms;
          rsp = make_rsp(pick, 1'b1, STAT_OK);
        end
      end
      KIND_SET_PRI, KIND_FINISH: begin
        if (!tbl_valid[cmd.slot_id]) begin
          rsp.status = STAT_BAD_SLOT;
        end else if (cmd.kind == KIND_SET_PRI) begin
          tbl_pri[cmd.slot_id] = (cmd.requested_priority < cfg_cap) ?
                                 PRI_W'(cmd.requested_priority) : cfg_cap;
        end else begin
          tbl_done[cmd.slot_id] = 1'b1;
        end
      end
      KIND_START: begin
        // Finished slots still count here.
        pick = best_slot(1'b0);
        if (pick >= 0) begin
          run_slot = SLOT_W'(pick);
          rsp = make_rsp(pick, 1'b1, STAT_OK);
        end
      end
      KIND_TICK: begin
        period = (cfg_period == '0) ? 1 : cfg_period;
        // Reclaim finished slots, except the one that is running.
        for (int i = 0; i < MAX_TASKS; i++)
          if (tbl_valid[i] && tbl_done[i] && i != run_slot) tbl_valid[i] = 1'b0;
        if (tbl_valid[run_slot])
          tbl_pri[run_slot] = (tbl_pri[run_slot] > cfg_penalty) ?
                              tbl_pri[run_slot] - cfg_penalty : '0;
        // Aging uses the wrapped wait since the slot last ran.
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (!tbl_valid[i]) continue;
          waited = cmd.now_ms - tbl_stamp[i];
          age    = waited / period;
          grown  = tbl_pri[i] + age;
          if (grown > cfg_cap) grown = cfg_cap;
          tbl_pri[i] = PRI_W'(grown);
        end
        pick = best_slot(1'b1);
        if (pick >= 0) begin
          run_slot        = SLOT_W'(pick);
          tbl_stamp[pick] = cmd.now_ms;
          rsp = make_rsp(pick, 1'b1, STAT_OK);
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic idle_for(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sends one request in bursts with random gaps, then records its result.
  task automatic issue(input in_req_t cmd, input bit fixed, input out_rsp_t fixed_rsp);
    out_rsp_t rsp;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0)
        idle_for($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = sched_step(cmd);
    pending_sched_results.insert(pending_sched_results.size(), fixed ? fixed_rsp : rsp);
    kinds_seen[cmd.kind]++;
    if (rsp.status == STAT_FULL) n_full++;
    if (rsp.status == STAT_BAD_SLOT) n_bad_slot++;
    if ((cmd.kind == KIND_START || cmd.kind == KIND_TICK) && !rsp.found) n_no_task++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_sched_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_AGING_PERIOD: cfg_period  = PER_W'(val);
      CFG_PRIORITY_CAP: cfg_cap     = PRI_W'(val);
      CFG_RUN_PENALTY:  cfg_penalty = PRI_W'(val);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker; the stall pattern cycles through four modes.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sched_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: slot %0d found %0b status %0d", $time,
                   out_data.chosen_slot, out_data.found, out_data.status);
      end else begin
        want = pending_sched_results.pop_front();
        if (out_data.chosen_slot !== want.chosen_slot || out_data.found !== want.found ||
            out_data.status !== want.status) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("[%0t] result error: slot %0d/%0d found %0b/%0b status %0d/%0d",
                     $time, out_data.chosen_slot, want.chosen_slot, out_data.found,
                     want.found, out_data.status, want.status);
        end
      end
    end
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 1) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (rx_cycle[4:0] < 5'd9);
    endcase
  end

  // Stimulus.
  initial begin
    plan_row_t plan[$];
    in_req_t   cmd;
    out_rsp_t  none;
    int        live[$];
    int        phase_period[PHASES];
    int        phase_cap[PHASES];
    int        phase_penalty[PHASES];
    int        sent;
    int        pick;
    int        free_cnt;

    none = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, run under the reset register values.
    plan.insert(plan.size(),
                '{make_cmd(KIND_TICK, 0, 0, 32'h0), 1'b1, make_rsp(0, 0, STAT_OK)});
    plan.insert(plan.size(),
                '{make_cmd(KIND_START, 0, 0, 32'h0), 1'b1, make_rsp(0, 0, STAT_OK)});
    plan.insert(plan.size(),
                '{make_cmd(KIND_SET_PRI, 15, 255, '1), 1'b1, make_rsp(0, 0, STAT_BAD_SLOT)});
    plan.insert(plan.size(),
                '{make_cmd(KIND_FINISH, 0, 0, 32'h0), 1'b1, make_rsp(0, 0, STAT_BAD_SLOT)});
    plan.insert(plan.size(), '{make_cmd(KIND_RESERVED_LO, 15, 255, '1), 1'b1, none});
    plan.insert(plan.size(),
                '{make_cmd(KIND_RESERVED_LO + 1'b1, 5, 128, 32'h5555_AAAA), 1'b1, none});
    plan.insert(plan.size(), '{make_cmd(KIND_RESERVED_HI, 10, 1, 32'hAAAA_5555), 1'b1, none});
    plan.insert(plan.size(),
                '{make_cmd(KIND_CREATE, 0, 0, 32'hFFFF_FFF0), 1'b1, make_rsp(0, 1, STAT_OK)});
    plan.insert(plan.size(),
                '{make_cmd(KIND_CREATE, 0, 0, 32'h0), 1'b1, make_rsp(1, 1, STAT_OK)});
    plan.insert(plan.size(),
                '{make_cmd(KIND_SET_PRI, 0, 255, 32'h0), 1'b1, make_rsp(0, 0, STAT_OK)});
    plan.insert(plan.size(),
                '{make_cmd(KIND_SET_PRI, 1, 0, 32'h0), 1'b1, make_rsp(0, 0, STAT_OK)});
    plan.insert(plan.size(),
                '{make_cmd(KIND_START, 0, 0, 32'h0), 1'b1, make_rsp(0, 1, STAT_OK)});
    // Wait time wraps around zero here.
    plan.insert(plan.size(), '{make_cmd(KIND_TICK, 0, 0, 32'h10), 1'b0, none});
    plan.insert(plan.size(),
                '{make_cmd(KIND_FINISH, 1, 0, 32'h0), 1'b1, make_rsp(0, 0, STAT_OK)});
    plan.insert(plan.size(), '{make_cmd(KIND_TICK, 0, 0, 32'd1000), 1'b0, none});
    plan.insert(plan.size(), '{make_cmd(KIND_CREATE, 0, 0, 32'd1000), 1'b0, none});
    plan.insert(plan.size(),
                '{make_cmd(KIND_FINISH, 0, 0, 32'h0), 1'b1, make_rsp(0, 0, STAT_OK)});
    // The running task is finished, so it is kept but not chosen.
    plan.insert(plan.size(), '{make_cmd(KIND_TICK, 0, 0, 32'd1020), 1'b0, none});
    plan.insert(plan.size(),
                '{make_cmd(KIND_FINISH, 1, 0, 32'h0), 1'b1, make_rsp(0, 0, STAT_OK)});
    plan.insert(plan.size(), '{make_cmd(KIND_TICK, 0, 0, 32'd1040), 1'b0, none});
    plan.insert(plan.size(), '{make_cmd(KIND_START, 0, 0, 32'h0), 1'b0, none});
    plan.insert(plan.size(),
                '{make_cmd(KIND_SET_PRI, 0, 5, 32'h0), 1'b1, make_rsp(0, 0, STAT_BAD_SLOT)});
    plan.insert(plan.size(), '{make_cmd(KIND_CREATE, 0, 0, '1), 1'b0, none});
    // A very long wait drives the new task straight to the cap.
    plan.insert(plan.size(), '{make_cmd(KIND_TICK, 0, 0, 32'h8000_0000), 1'b0, none});
    foreach (plan[i]) issue(plan[i].cmd, plan[i].fixed, plan[i].rsp);
    sim_ms = 32'h8000_0000;
    wait_results();

    // Register settings for the random phases; one of them is drawn at random.
    phase_period  = '{1, 255, 7, 1, 0, 20};
    phase_cap     = '{127, 127, 30, 0, 0, 100};
    phase_penalty = '{0, 127, 1, 0, 0, 2};
    phase_period[4]  = $urandom_range(1, 255);
    phase_cap[4]     = $urandom_range(0, 127);
    phase_penalty[4] = $urandom_range(0, 127);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results();
      write_reg(CFG_AGING_PERIOD, CFG_DAT_W'(phase_period[ph]));
      write_reg(CFG_PRIORITY_CAP, CFG_DAT_W'(phase_cap[ph]));
      write_reg(CFG_RUN_PENALTY, CFG_DAT_W'(phase_penalty[ph]));
      n_settings++;
      sent = 0;
      while (sent < PHASE_CMDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          // Fill the table and push one create past full.
          free_cnt = 0;
          foreach (tbl_valid[i]) if (!tbl_valid[i]) free_cnt++;
          repeat (free_cnt + 1) begin
            sim_ms += $urandom_range(0, 3);
            issue(make_cmd(KIND_CREATE, $urandom, $urandom, sim_ms), 1'b0, none);
          end
          sent += free_cnt + 1;
        end else if (pick < 4) begin
          // Finish every live task, then tick with nothing left to run.
          for (int i = 0; i < MAX_TASKS; i++)
            if (tbl_valid[i] && !tbl_done[i]) begin
              issue(make_cmd(KIND_FINISH, i, $urandom, $urandom), 1'b0, none);
              sent++;
            end
          sim_ms += $urandom_range(0, 50);
          issue(make_cmd(KIND_TICK, $urandom, $urandom, sim_ms), 1'b0, none);
          sent++;
        end else begin
          cmd = make_cmd(KIND_CREATE, $urandom, $urandom, $urandom);
          if (pick < 22) begin
            cmd.now_ms = sim_ms;
          end else if (pick < 48) begin
            cmd.kind = (pick < 38) ? KIND_SET_PRI : KIND_FINISH;
            live.delete();
            foreach (tbl_valid[i]) if (tbl_valid[i]) live.insert(live.size(), i);
            if (live.size() != 0 && $urandom_range(0, 4) != 0)
              cmd.slot_id = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
            if ($urandom_range(0, 2) == 0)
              cmd.requested_priority = REQ_PRI_W'(cfg_cap) + REQ_PRI_W'($urandom_range(0, 1));
          end else if (pick < 56) begin
            cmd.kind = KIND_START;
          end else if (pick < 96) begin
            cmd.kind = KIND_TICK;
            pick = $urandom_range(0, 99);
            if (pick < 85)
              sim_ms += $urandom_range(0, 4 * cfg_period);
            else if (pick < 92)
              sim_ms += $urandom_range(0, 100000);
            else if (pick < 96)
              sim_ms = '1 - $urandom_range(0, 500);
            else
              sim_ms = $urandom;
            cmd.now_ms = sim_ms;
          end else begin
            cmd.kind = KIND_W'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
          end
          issue(cmd, 1'b0, none);
          sent++;
        end
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d create, %0d set priority, %0d finish, %0d start, %0d tick and %0d ignored",
             kinds_seen[KIND_CREATE], kinds_seen[KIND_SET_PRI], kinds_seen[KIND_FINISH],
             kinds_seen[KIND_START], kinds_seen[KIND_TICK],
             kinds_seen[5] + kinds_seen[6] + kinds_seen[7]);
    $display("commands over %0d register settings; %0d full, %0d bad slot, %0d idle picks.",
             n_settings, n_full, n_bad_slot, n_no_task);
    if (err_count == 0 && pending_sched_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/aps_pkg.sv
src/aps_div.sv
src/aging_priority_task_scheduler_core.sv
tb/sv/tb_top.sv
